// ===== rtl/mpt_pkg.sv =====
// Shared types, constants and codes for the multilevel page table.
package mpt_pkg;

  localparam int ADDRESS_BITS  = 32;
  localparam int FRAME_BITS    = 20;
  localparam int ENTRY_W       = FRAME_BITS + 1;
  localparam int NUM_LEVELS    = 4;
  localparam int MAX_LEVELS    = 4;
  localparam int LEVEL_COUNT_W = 3;
  localparam int LEVEL_BITS_W  = 4;
  localparam int DEPTH_W       = $clog2(NUM_LEVELS);
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 4;
  localparam int STATUS_W      = 3;

  localparam int DEF_MAX_LEVEL_BITS = 8;
  localparam int DEF_NODE_POOL      = 256;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT      = 3'd0,
    ST_MISS     = 3'd1,
    ST_INSERTED = 3'd2,
    ST_MAPPED   = 3'd3,
    ST_FULL     = 3'd4,
    ST_BADCFG   = 3'd5
  } mpt_status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LEVEL_COUNT = 3'd0,
    CFG_LEVEL0_BITS = 3'd1,
    CFG_LEVEL1_BITS = 3'd2,
    CFG_LEVEL2_BITS = 3'd3,
    CFG_LEVEL3_BITS = 3'd4
  } mpt_cfg_index_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_ALLOC,
    S_DONE
  } mpt_state_t;

  typedef struct packed {
    logic [LEVEL_COUNT_W-1:0]                 level_count;
    logic [NUM_LEVELS-1:0][LEVEL_BITS_W-1:0]  level_bits;
    logic                                     bad;
  } mpt_cfg_t;

endpackage

// ===== rtl/mpt_node_mem.sv =====
// Node store: one write port, one read port, registered read data.
module mpt_node_mem #(
  parameter int DEPTH  = mpt_pkg::DEF_NODE_POOL * (2 ** mpt_pkg::DEF_MAX_LEVEL_BITS),
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [mpt_pkg::ENTRY_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [mpt_pkg::ENTRY_W-1:0] rd_data
);
  import mpt_pkg::*;

  logic [ENTRY_W-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/mpt_cfg_regs.sv =====
// Configuration registers, config validity check and table-clear request.
module mpt_cfg_regs #(
  parameter int MAX_LEVEL_BITS = mpt_pkg::DEF_MAX_LEVEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mpt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mpt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output mpt_pkg::mpt_cfg_t              cfg,
  output logic                           clear
);
  import mpt_pkg::*;

  localparam int SUM_W = LEVEL_BITS_W + DEPTH_W;

  logic [LEVEL_COUNT_W-1:0]                level_count;
  logic [NUM_LEVELS-1:0][LEVEL_BITS_W-1:0] level_bits;
  logic                                    known_index;
  logic                                    bad;
  logic [SUM_W-1:0]                        used;

  assign cfg_ready = 1'b1;

  always_comb begin
    case (cfg_index)
      CFG_LEVEL_COUNT, CFG_LEVEL0_BITS, CFG_LEVEL1_BITS,
      CFG_LEVEL2_BITS, CFG_LEVEL3_BITS: known_index = 1'b1;
      default:                          known_index = 1'b0;
    endcase
  end

  // A write to an unknown index leaves the table alone
  assign clear = cfg_valid && cfg_ready && known_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= LEVEL_COUNT_W'(2);
      for (int i = 0; i < NUM_LEVELS; i++) begin
        level_bits[i] <= LEVEL_BITS_W'(8);
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEVEL_COUNT: level_count   <= cfg_data[LEVEL_COUNT_W-1:0];
        CFG_LEVEL0_BITS: level_bits[0] <= cfg_data[LEVEL_BITS_W-1:0];
        CFG_LEVEL1_BITS: level_bits[1] <= cfg_data[LEVEL_BITS_W-1:0];
        CFG_LEVEL2_BITS: level_bits[2] <= cfg_data[LEVEL_BITS_W-1:0];
        CFG_LEVEL3_BITS: level_bits[3] <= cfg_data[LEVEL_BITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bad  = (level_count == '0) ||
           (level_count > LEVEL_COUNT_W'(NUM_LEVELS)) ||
           (level_count > LEVEL_COUNT_W'(MAX_LEVELS));
    used = '0;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (LEVEL_COUNT_W'(i) < level_count) begin
        if (level_bits[i] == '0 || level_bits[i] > LEVEL_BITS_W'(MAX_LEVEL_BITS)) begin
          bad = 1'b1;
        end
        used = used + SUM_W'(level_bits[i]);
      end
    end
    if (used > SUM_W'(ADDRESS_BITS)) begin
      bad = 1'b1;
    end
  end

  assign cfg.level_count = level_count;
  assign cfg.level_bits  = level_bits;
  assign cfg.bad         = bad;

endmodule

// ===== rtl/mpt_walker.sv =====
// Walk/insert sequencer: clear sweep, per-level reads, node allocation, result register.
module mpt_walker #(
  parameter int MAX_LEVEL_BITS = mpt_pkg::DEF_MAX_LEVEL_BITS,
  parameter int NODE_POOL      = mpt_pkg::DEF_NODE_POOL
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mpt_pkg::mpt_cfg_t                cfg,
  input  logic                             clear,
  input  logic                             cfg_valid,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             op,
  input  logic [mpt_pkg::ADDRESS_BITS-1:0] logical_address,
  input  logic [mpt_pkg::FRAME_BITS-1:0]   frame_in,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [mpt_pkg::STATUS_W-1:0]     status,
  output logic [mpt_pkg::FRAME_BITS-1:0]   frame_out,
  output logic                             wr_en,
  output logic [$clog2(NODE_POOL)+MAX_LEVEL_BITS-1:0] wr_addr,
  output logic [mpt_pkg::ENTRY_W-1:0]      wr_data,
  output logic                             rd_en,
  output logic [$clog2(NODE_POOL)+MAX_LEVEL_BITS-1:0] rd_addr,
  input  logic [mpt_pkg::ENTRY_W-1:0]      rd_data
);
  import mpt_pkg::*;

  localparam int NODE_W = $clog2(NODE_POOL);
  localparam int ADDR_W = NODE_W + MAX_LEVEL_BITS;
  localparam int DEPTH  = NODE_POOL * (2 ** MAX_LEVEL_BITS);
  localparam int CNT_W  = $clog2(NODE_POOL + 1);
  localparam int NEED_W = CNT_W + DEPTH_W;

  function automatic logic [MAX_LEVEL_BITS-1:0] idx_of(
    input logic [ADDRESS_BITS-1:0] sh,
    input logic [LEVEL_BITS_W-1:0] w
  );
    idx_of = sh[ADDRESS_BITS-1 -: MAX_LEVEL_BITS] >> (LEVEL_BITS_W'(MAX_LEVEL_BITS) - w);
  endfunction

  mpt_state_t              state, state_next;
  logic [ADDR_W-1:0]       clr_addr, clr_addr_next;
  logic [CNT_W-1:0]        next_free, next_free_next;
  logic                    op_r, op_r_next;
  logic [ADDRESS_BITS-1:0] addr_sh, addr_sh_next;
  logic [FRAME_BITS-1:0]   frame_r, frame_r_next;
  logic [NODE_W-1:0]       node, node_next;
  logic [DEPTH_W-1:0]      depth, depth_next;
  mpt_status_t             res_status, res_status_next;
  logic [FRAME_BITS-1:0]   res_frame, res_frame_next;
  logic                    rsp_valid_next;
  mpt_status_t             rsp_status, rsp_status_next;
  logic [FRAME_BITS-1:0]   rsp_frame, rsp_frame_next;

  logic [LEVEL_COUNT_W-1:0] lc_m1;
  logic [DEPTH_W-1:0]       last;
  logic [DEPTH_W-1:0]       needed;
  logic                     pool_full;
  logic [MAX_LEVEL_BITS-1:0] idx_cur;
  logic                     e_valid;
  logic [FRAME_BITS-1:0]    e_data;
  logic                     child_ok;
  logic [ADDRESS_BITS-1:0]  sh_adv;

  assign lc_m1     = cfg.level_count - LEVEL_COUNT_W'(1);
  assign last      = lc_m1[DEPTH_W-1:0];
  assign needed    = last - depth;
  assign pool_full = (NEED_W'(next_free) + NEED_W'(needed)) > NEED_W'(NODE_POOL);
  assign idx_cur   = idx_of(addr_sh, cfg.level_bits[depth]);
  assign e_valid   = rd_data[ENTRY_W-1];
  assign e_data    = rd_data[FRAME_BITS-1:0];
  assign child_ok  = e_valid && (e_data < FRAME_BITS'(NODE_POOL));
  assign sh_adv    = addr_sh << cfg.level_bits[depth];

  assign req_stall = (state != S_IDLE) || cfg_valid;
  assign status    = rsp_status;
  assign frame_out = rsp_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      next_free <= CNT_W'(1);
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      next_free <= next_free_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_r_next;
    addr_sh    <= addr_sh_next;
    frame_r    <= frame_r_next;
    node       <= node_next;
    depth      <= depth_next;
    res_status <= res_status_next;
    res_frame  <= res_frame_next;
    rsp_status <= rsp_status_next;
    rsp_frame  <= rsp_frame_next;
  end

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    next_free_next  = next_free;
    op_r_next       = op_r;
    addr_sh_next    = addr_sh;
    frame_r_next    = frame_r;
    node_next       = node;
    depth_next      = depth;
    res_status_next = res_status;
    res_frame_next  = res_frame;
    rsp_valid_next  = rsp_valid && rsp_stall;
    rsp_status_next = rsp_status;
    rsp_frame_next  = rsp_frame;
    wr_en           = 1'b0;
    wr_addr         = {node, idx_cur};
    wr_data         = '0;
    rd_en           = 1'b0;
    rd_addr         = {node, idx_cur};

    case (state)
      S_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        clr_addr_next = clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid && !req_stall) begin
          op_r_next       = op;
          frame_r_next    = frame_in;
          addr_sh_next    = logical_address;
          node_next       = '0;
          depth_next      = '0;
          res_frame_next  = '0;
          if (cfg.bad) begin
            res_status_next = ST_BADCFG;
            state_next      = S_DONE;
          end else begin
            // root read goes out on the accepting edge
            rd_en      = 1'b1;
            rd_addr    = {{NODE_W{1'b0}}, idx_of(logical_address, cfg.level_bits[0])};
            state_next = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (depth != last) begin
          if (child_ok) begin
            node_next    = e_data[NODE_W-1:0];
            depth_next   = depth + DEPTH_W'(1);
            addr_sh_next = sh_adv;
            rd_en        = 1'b1;
            rd_addr      = {e_data[NODE_W-1:0],
                            idx_of(sh_adv, cfg.level_bits[depth + DEPTH_W'(1)])};
          end else if (!op_r) begin
            res_status_next = ST_MISS;
            state_next      = S_DONE;
          end else if (pool_full) begin
            res_status_next = ST_FULL;
            state_next      = S_DONE;
          end else begin
            state_next = S_ALLOC;
          end
        end else begin
          state_next = S_DONE;
          if (e_valid) begin
            if (!op_r) begin
              res_status_next = ST_HIT;
              res_frame_next  = e_data;
            end else begin
              res_status_next = ST_MAPPED;
            end
          end else if (!op_r) begin
            res_status_next = ST_MISS;
          end else begin
            wr_en           = 1'b1;
            wr_data         = {1'b1, frame_r};
            res_status_next = ST_INSERTED;
          end
        end
      end

      S_ALLOC: begin
        wr_en = 1'b1;
        if (depth != last) begin
          // link a fresh node into the hole, then descend into it
          wr_data        = {1'b1, FRAME_BITS'(next_free)};
          node_next      = next_free[NODE_W-1:0];
          next_free_next = next_free + CNT_W'(1);
          depth_next     = depth + DEPTH_W'(1);
          addr_sh_next   = sh_adv;
        end else begin
          wr_data         = {1'b1, frame_r};
          res_status_next = ST_INSERTED;
          state_next      = S_DONE;
        end
      end

      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_valid_next  = 1'b1;
          rsp_status_next = res_status;
          rsp_frame_next  = res_frame;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (clear) begin
      state_next     = S_CLEAR;
      clr_addr_next  = '0;
      next_free_next = CNT_W'(1);
    end
  end

endmodule

// ===== rtl/multilevel_page_table.sv =====
// Top level of the multilevel page table: config registers, walker and node store.
//
//   channel  direction  handshake              beat carries
//   req      in         req_valid / req_stall  op, logical_address, frame_in
//   rsp      out        rsp_valid / rsp_stall  status, frame_out
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A walk reads or writes the node store level by level; a bad-config request
// skips the walk and goes straight to the result register.
// After reset and after every register write to a known index, the store is
// swept clear one entry a cycle, NODE_POOL * 2**MAX_LEVEL_BITS entries (65536 at
// default), with requests stalled. A finished result waits in the output register
// while the next request is walked.
module multilevel_page_table #(
  parameter int MAX_LEVEL_BITS = mpt_pkg::DEF_MAX_LEVEL_BITS,
  parameter int NODE_POOL      = mpt_pkg::DEF_NODE_POOL
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             op,
  input  logic [mpt_pkg::ADDRESS_BITS-1:0] logical_address,
  input  logic [mpt_pkg::FRAME_BITS-1:0]   frame_in,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [mpt_pkg::STATUS_W-1:0]     status,
  output logic [mpt_pkg::FRAME_BITS-1:0]   frame_out,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mpt_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mpt_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mpt_pkg::*;

  localparam int NODE_W = $clog2(NODE_POOL);
  localparam int ADDR_W = NODE_W + MAX_LEVEL_BITS;
  localparam int DEPTH  = NODE_POOL * (2 ** MAX_LEVEL_BITS);

  mpt_cfg_t            cfg;
  logic                clear;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0]  rd_data;

  mpt_cfg_regs #(
    .MAX_LEVEL_BITS (MAX_LEVEL_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .clear     (clear)
  );

  mpt_node_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mpt_walker #(
    .MAX_LEVEL_BITS (MAX_LEVEL_BITS),
    .NODE_POOL      (NODE_POOL)
  ) u_walker (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .clear           (clear),
    .cfg_valid       (cfg_valid),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .op              (op),
    .logical_address (logical_address),
    .frame_in        (frame_in),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .status          (status),
    .frame_out       (frame_out),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr),
    .rd_data         (rd_data)
  );

endmodule

// ===== sim/tb_multilevel_page_table.sv =====
// Self-checking testbench for the multilevel page table: directed table, then random walks.
`timescale 1ns / 1ps

module tb_multilevel_page_table;
  import mpt_pkg::*;

  localparam int  NODE_POOL    = DEF_NODE_POOL;
  localparam int  ROW_SIZE     = 1 << DEF_MAX_LEVEL_BITS;
  localparam logic OP_LOOKUP   = 1'b0;
  localparam logic OP_INSERT   = 1'b1;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
  localparam int  SETTLE_CYCLES = 2 * NUM_LEVELS + 8;
  localparam int  LONG_HOLD     = 300;
  // 13 store sweeps of 65536 entries plus ~530 beats at worst-case gaps, taken four times over
  localparam int  CYCLE_LIMIT   = 4_000_000;

  typedef struct packed {
    mpt_status_t           st;
    logic [FRAME_BITS-1:0] fr;
  } page_result_t;

  typedef struct {
    logic                    op;
    logic [ADDRESS_BITS-1:0] addr;
    logic [FRAME_BITS-1:0]   frame;
    bit                      typed;
    mpt_status_t             st;
    logic [FRAME_BITS-1:0]   fr;
  } dir_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_stall;
  logic                        op = 1'b0;
  logic [ADDRESS_BITS-1:0]     logical_address = '0;
  logic [FRAME_BITS-1:0]       frame_in = '0;
  logic                        rsp_valid;
  logic                        rsp_stall = 1'b1;
  logic [STATUS_W-1:0]         status;
  logic [FRAME_BITS-1:0]       frame_out;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_INDEX_W-1:0]      cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  // predictor state
  logic [ENTRY_W-1:0]          node_rows [NODE_POOL*ROW_SIZE];
  int                          next_node;
  logic [LEVEL_COUNT_W-1:0]    cfg_count;
  logic [LEVEL_BITS_W-1:0]     cfg_bits [NUM_LEVELS];

  page_result_t                due_results[$];
  logic [ADDRESS_BITS-1:0]     addr_hist[$];
  int                          mismatches = 0;
  int                          results_seen = 0;
  int                          requests_sent = 0;
  int                          reg_writes = 0;
  int                          status_seen [6] = '{default: 0};
  int                          cycle_count = 0;
  bit                          rsp_beat = 1'b0;
  bit                          tx_quiet = 1'b0;
  bit                          rx_quiet = 1'b0;
  int                          rx_wait = 0;
  int                          rx_hold = 0;
  int                          hold_asks = 0;
  int                          hold_taken = 0;

  localparam int DIR_ROWS = 20;
  // reset shape: two levels of 8 bits, indices are addr[31:24] and addr[23:16]
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_LOOKUP, 32'h0000_0000, 20'h00000, 1'b1, ST_MISS,     20'h00000},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1, ST_MISS,     20'h00000},
    '{OP_INSERT, 32'h0000_0000, 20'h00000, 1'b1, ST_INSERTED, 20'h00000},
    '{OP_INSERT, 32'hFFFF_FFFF, 20'hFFFFF, 1'b1, ST_INSERTED, 20'h00000},
    '{OP_LOOKUP, 32'h0000_0000, 20'hFFFFF, 1'b1, ST_HIT,      20'h00000},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 20'h00000, 1'b1, ST_HIT,      20'hFFFFF},
    '{OP_INSERT, 32'hFFFF_FFFF, 20'h12345, 1'b1, ST_MAPPED,   20'h00000},
    '{OP_LOOKUP, 32'hFFFF_FFFF, 20'h00000, 1'b1, ST_HIT,      20'hFFFFF},
    '{OP_LOOKUP, 32'hFF00_FFFF, 20'h00000, 1'b1, ST_MISS,     20'h00000},
    '{OP_LOOKUP, 32'h0000_FFFF, 20'h00000, 1'b1, ST_HIT,      20'h00000},
    '{OP_INSERT, 32'hFFFE_0000, 20'hAAAAA, 1'b0, ST_HIT,      20'h00000},
    '{OP_LOOKUP, 32'hFFFE_FFFF, 20'hFFFFF, 1'b0, ST_HIT,      20'h00000},
    '{OP_INSERT, 32'h1234_0000, 20'h55555, 1'b0, ST_HIT,      20'h00000},
    '{OP_LOOKUP, 32'h1234_ABCD, 20'h00000, 1'b0, ST_HIT,      20'h00000},
    '{OP_INSERT, 32'h8000_0000, 20'h00001, 1'b0, ST_HIT,      20'h00000},
    '{OP_LOOKUP, 32'h7FFF_FFFF, 20'h00000, 1'b0, ST_HIT,      20'h00000},
    '{OP_LOOKUP, 32'h8001_0000, 20'h00000, 1'b0, ST_HIT,      20'h00000},
    '{OP_INSERT, 32'h0001_0000, 20'hFFFFF, 1'b0, ST_HIT,      20'h00000},
    '{OP_LOOKUP, 32'h0001_0000, 20'h00000, 1'b0, ST_HIT,      20'h00000},
    '{OP_INSERT, 32'h1234_5678, 20'h0F0F0, 1'b0, ST_HIT,      20'h00000}
  };

  multilevel_page_table i_dut (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .op              (op),
    .logical_address (logical_address),
    .frame_in        (frame_in),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .status          (status),
    .frame_out       (frame_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timed out after %0d cycles, %0d results outstanding",
               $time, cycle_count, due_results.size());
      $display("tb_multilevel_page_table NOT OK");
      $finish;
    end
  end

  function automatic void clear_table();
    for (int k = 0; k < NODE_POOL * ROW_SIZE; k++) node_rows[k] = '0;
    next_node = 1;
  endfunction

  task automatic walk_table(input logic o, input logic [ADDRESS_BITS-1:0] a,
                            input logic [FRAME_BITS-1:0] f,
                            output mpt_status_t st, output logic [FRAME_BITS-1:0] fo);
    int          ix [NUM_LEVELS];
    int          used;
    int          w;
    int          d;
    int          last;
    int          nd;
    bit          bad;
    logic [63:0] wide;
    logic [ENTRY_W-1:0] e;
    fo   = '0;
    st   = ST_BADCFG;
    used = 0;
    bad  = (cfg_count == 0) || (cfg_count > MAX_LEVELS);
    if (!bad) begin
      for (int i = 0; i < cfg_count; i++) begin
        if (cfg_bits[i] == 0 || cfg_bits[i] > DEF_MAX_LEVEL_BITS) bad = 1'b1;
        used += cfg_bits[i];
      end
    end
    if (bad || used > ADDRESS_BITS) return;

    wide = {32'd0, a};
    used = 0;
    for (int i = 0; i < cfg_count; i++) begin
      w     = cfg_bits[i];
      ix[i] = int'((wide >> (ADDRESS_BITS - used - w)) & ((64'd1 << w) - 1));
      used += w;
    end

    last = cfg_count - 1;
    nd   = 0;
    for (d = 0; d < last; d++) begin
      e = node_rows[nd*ROW_SIZE + ix[d]];
      if (!e[ENTRY_W-1] || e[FRAME_BITS-1:0] >= NODE_POOL) break;
      nd = e[FRAME_BITS-1:0];
    end

    if (d == last) begin
      e = node_rows[nd*ROW_SIZE + ix[last]];
      if (e[ENTRY_W-1]) begin
        if (o == OP_LOOKUP) begin
          st = ST_HIT;
          fo = e[FRAME_BITS-1:0];
        end else begin
          st = ST_MAPPED;
        end
      end else if (o == OP_LOOKUP) begin
        st = ST_MISS;
      end else begin
        node_rows[nd*ROW_SIZE + ix[last]] = {1'b1, f};
        st = ST_INSERTED;
      end
    end else if (o == OP_LOOKUP) begin
      st = ST_MISS;
    end else if (next_node + (last - d) > NODE_POOL) begin
      // all or nothing: no partial chain is built
      st = ST_FULL;
    end else begin
      while (d < last) begin
        node_rows[nd*ROW_SIZE + ix[d]] = {1'b1, FRAME_BITS'(next_node)};
        nd = next_node;
        next_node++;
        d++;
      end
      node_rows[nd*ROW_SIZE + ix[last]] = {1'b1, f};
      st = ST_INSERTED;
    end
  endtask

  // one request beat; the result is worked out when the beat is taken
  task automatic send_item(input logic o, input logic [ADDRESS_BITS-1:0] a,
                           input logic [FRAME_BITS-1:0] f, input bit typed,
                           input mpt_status_t ts, input logic [FRAME_BITS-1:0] tf);
    int                    gap;
    mpt_status_t           ps;
    logic [FRAME_BITS-1:0] pf;
    if ($urandom_range(0, 24) == 0) tx_quiet = !tx_quiet;
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid       <= 1'b1;
    op              <= o;
    logical_address <= a;
    frame_in        <= f;
    do @(posedge clk); while (!(req_valid && !req_stall));
    walk_table(o, a, f, ps, pf);
    if (typed) due_results.push_back('{st: ts, fr: tf});
    else       due_results.push_back('{st: ps, fr: pf});
    requests_sent++;
    addr_hist.push_back(a);
    if (addr_hist.size() > 64) void'(addr_hist.pop_front());
  endtask

  task automatic random_items(input int count, input int insert_pct, input int fresh_pct);
    int                      sel;
    logic [ADDRESS_BITS-1:0] a;
    logic [FRAME_BITS-1:0]   f;
    logic                    o;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (addr_hist.size() == 0 || sel < fresh_pct) begin
        a = $urandom();
      end else begin
        a = addr_hist[$urandom_range(0, addr_hist.size() - 1)];
        // keep the upper indices, vary the rest: shares a partial walk
        if (sel >= 85)      a[23:0] = 24'($urandom());
        else if (sel >= 70) a[15:0] = 16'($urandom());
      end
      case ($urandom_range(0, 9))
        0:       f = '0;
        1:       f = '1;
        default: f = FRAME_BITS'($urandom());
      endcase
      o = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_LOOKUP;
      send_item(o, a, f, 1'b0, ST_HIT, '0);
    end
  endtask

  task automatic drain_results();
    @(negedge clk) req_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    reg_writes++;
    case (idx)
      CFG_LEVEL_COUNT: cfg_count   = val[LEVEL_COUNT_W-1:0];
      CFG_LEVEL0_BITS: cfg_bits[0] = val;
      CFG_LEVEL1_BITS: cfg_bits[1] = val;
      CFG_LEVEL2_BITS: cfg_bits[2] = val;
      CFG_LEVEL3_BITS: cfg_bits[3] = val;
      default:         ;
    endcase
    // an unused index leaves the table alone
    if (idx <= CFG_LEVEL3_BITS) clear_table();
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : check_rsp
    page_result_t want;
    rsp_beat = !rst && rsp_valid && !rsp_stall;
    if (rsp_beat) begin
      results_seen++;
      if (status < 6) status_seen[status]++;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result beat: status %0d frame %h", $time, status, frame_out);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          mismatches++;
        end
        if (frame_out !== want.fr) begin
          $display("%0t: frame_out expected %h actual %h", $time, want.fr, frame_out);
          mismatches++;
        end
      end
    end
  end

  // response side back-pressure; long holds are counted here
  always @(negedge clk) begin
    if (rsp_beat) begin
      if ($urandom_range(0, 29) == 0) rx_quiet = !rx_quiet;
      rx_wait = rx_quiet ? 0 : $urandom_range(0, 13);
    end
    if (hold_asks != hold_taken) begin
      hold_taken = hold_asks;
      rx_hold    = LONG_HOLD;
    end
    rsp_stall <= (rx_hold != 0) || (rx_wait != 0);
    if (rx_hold != 0)      rx_hold--;
    else if (rx_wait != 0) rx_wait--;
  end

  initial begin : stimulus
    cfg_count = 3'd2;
    for (int i = 0; i < NUM_LEVELS; i++) cfg_bits[i] = 4'd8;
    clear_table();
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++)
      send_item(dir_rows[r].op, dir_rows[r].addr, dir_rows[r].frame,
                dir_rows[r].typed, dir_rows[r].st, dir_rows[r].fr);
    random_items(30, 50, 40);
    hold_asks++;
    random_items(40, 50, 40);
    drain_results();

    // four levels of 8 bits, full address used; insert-heavy to run the pool dry
    write_reg(CFG_LEVEL_COUNT, 4'd4);
    random_items(80, 80, 60);
    drain_results();
    random_items(80, 80, 60);
    drain_results();

    write_reg(CFG_LEVEL_COUNT, 4'd1);
    random_items(50, 50, 40);
    drain_results();

    write_reg(CFG_LEVEL0_BITS, 4'd1);
    random_items(25, 50, 40);
    drain_results();

    // narrow four-level tree: 1+2+3+1 index bits
    write_reg(CFG_LEVEL_COUNT, 4'd4);
    write_reg(CFG_LEVEL1_BITS, 4'd2);
    write_reg(CFG_LEVEL2_BITS, 4'd3);
    write_reg(CFG_LEVEL3_BITS, 4'd1);
    random_items(70, 50, 40);
    drain_results();

    // zero-width level in use
    write_reg(CFG_LEVEL3_BITS, 4'd0);
    random_items(15, 50, 40);
    drain_results();

    // same zero width, but that level is now beyond the count
    write_reg(CFG_LEVEL_COUNT, 4'd3);
    random_items(50, 50, 40);
    drain_results();
    write_reg(CFG_UNUSED_INDEX, 4'hF);
    random_items(25, 30, 20);
    drain_results();

    write_reg(CFG_LEVEL2_BITS, 4'd15);
    random_items(12, 50, 40);
    drain_results();

    write_reg(CFG_LEVEL_COUNT, 4'd0);
    random_items(12, 50, 40);
    drain_results();

    write_reg(CFG_LEVEL_COUNT, 4'd5);
    random_items(12, 50, 40);
    drain_results();

    $display("%0d requests, %0d results checked over %0d register writes, %0d mismatches",
             requests_sent, results_seen, reg_writes, mismatches);
    $display("hit %0d, miss %0d, inserted %0d, already mapped %0d, pool full %0d, bad config %0d",
             status_seen[ST_HIT], status_seen[ST_MISS], status_seen[ST_INSERTED],
             status_seen[ST_MAPPED], status_seen[ST_FULL], status_seen[ST_BADCFG]);
    if (mismatches == 0) begin
      $display("tb_multilevel_page_table OK");
    end else begin
      $display("tb_multilevel_page_table NOT OK");
    end
    $finish;
  end

endmodule
